### hw/rtl/rbhw_pkg.sv
// ----------------------------------------------------------------------------
// rbhw_pkg: shared types for the RAR block header walker
// Result word layout passed from the parser to the output register.
// ----------------------------------------------------------------------------
package rbhw_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned FNUM_W  = 16;

   localparam logic KIND_NAME  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic [FNUM_W-1:0]  file_number;
      logic               last_of_name;
   } rsp_type;

endpackage

### hw/rtl/rbhw_parser.sv
// ----------------------------------------------------------------------------
// rbhw_parser: block header field gatherer
// Walks the archive one byte per step, gathers block and file headers,
// produces name-byte and file-count result words.
// ----------------------------------------------------------------------------
module rbhw_parser #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   is_end,
   output rbhw_pkg::rsp_type      result
);
   import rbhw_pkg::*;

   localparam logic [1:0] PH_SKIP  = 2'd0;
   localparam logic [1:0] PH_BLOCK = 2'd1;
   localparam logic [1:0] PH_FILE  = 2'd2;
   localparam logic [1:0] PH_NAME  = 2'd3;

   localparam logic [4:0] POS_TYPE    = 5'd2;
   localparam logic [4:0] POS_HSIZE_L = 5'd5;
   localparam logic [4:0] POS_HSIZE_H = 5'd6;
   localparam logic [4:0] POS_NLEN_L  = 5'd19;
   localparam logic [4:0] POS_NLEN_H  = 5'd20;
   localparam logic [4:0] POS_FILE_LAST = 5'd24;

   localparam logic [15:0] BLOCK_HDR_LEN = 16'd7;
   localparam logic [33:0] USED_LEN      = 34'd32;
   localparam logic [33:0] MARKER_LEN    = 34'd7;
   localparam logic [7:0]  FILE_BLOCK_TYPE = 8'h74;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [1:0]            phase_ff, phase_in;
   logic [4:0]            bib_ff, bib_in;
   logic [7:0]            type_ff, type_in;
   logic [15:0]           hsize_ff, hsize_in;
   logic [31:0]           packed_ff, packed_in;
   logic [15:0]           nlen_ff, nlen_in;
   logic [33:0]           skip_ff, skip_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [33:0] skip_dec;
   logic [33:0] total;
   logic [33:0] file_rem;
   logic [15:0] hdr_rem;
   logic [31:0] count_wide;
   logic [15:0] count_sat;

   assign skip_dec   = (skip_ff == '0) ? '0 : skip_ff - 34'd1;
   assign total      = 34'(hsize_ff) + 34'(packed_ff);
   assign file_rem   = (total > USED_LEN) ? total - USED_LEN : '0;
   assign hdr_rem    = (hsize_in > BLOCK_HDR_LEN) ? hsize_in - BLOCK_HDR_LEN : '0;
   assign count_wide = 32'(count_ff);
   assign count_sat  = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];

   always_comb begin
      phase_in  = phase_ff;
      bib_in    = bib_ff;
      type_in   = type_ff;
      hsize_in  = hsize_ff;
      packed_in = packed_ff;
      nlen_in   = nlen_ff;
      skip_in   = skip_ff;
      count_in  = count_ff;
      result    = '0;

      if (is_end) begin
         result.valid = 1'b1;
         result.kind  = KIND_COUNT;
         result.value = count_sat;
      end else begin
         unique case (phase_ff)
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_BLOCK;
                  bib_in   = '0;
               end
            end
            PH_BLOCK: begin
               if (bib_ff == POS_TYPE) type_in = data_byte;
               if (bib_ff == POS_HSIZE_L) hsize_in[7:0] = data_byte;
               if (bib_ff == POS_HSIZE_H) hsize_in[15:8] = data_byte;
               bib_in = bib_ff + 5'd1;
               if (bib_ff == POS_HSIZE_H) begin
                  bib_in = '0;
                  if (type_ff == FILE_BLOCK_TYPE) begin
                     if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
                     phase_in = PH_FILE;
                  end else begin
                     skip_in  = 34'(hdr_rem);
                     phase_in = (hdr_rem == '0) ? PH_BLOCK : PH_SKIP;
                  end
               end
            end
            PH_FILE: begin
               if (bib_ff < 5'd4) packed_in[{bib_ff[1:0], 3'b000} +: 8] = data_byte;
               if (bib_ff == POS_NLEN_L) nlen_in[7:0] = data_byte;
               if (bib_ff == POS_NLEN_H) nlen_in[15:8] = data_byte;
               bib_in = bib_ff + 5'd1;
               if (bib_ff == POS_FILE_LAST) begin
                  bib_in  = '0;
                  skip_in = file_rem;
                  if (nlen_ff == '0)
                     phase_in = (file_rem == '0) ? PH_BLOCK : PH_SKIP;
                  else
                     phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               result.valid        = 1'b1;
               result.kind         = KIND_NAME;
               result.value        = 16'(data_byte);
               result.file_number  = count_sat;
               result.last_of_name = (nlen_ff <= 16'd1);
               skip_in = skip_dec;
               nlen_in = (nlen_ff == '0) ? '0 : nlen_ff - 16'd1;
               // last name byte: drop into the skip over packed data
               if (nlen_ff <= 16'd1) begin
                  nlen_in  = '0;
                  bib_in   = '0;
                  phase_in = (skip_dec == '0) ? PH_BLOCK : PH_SKIP;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         bib_ff    <= '0;
         type_ff   <= '0;
         hsize_ff  <= '0;
         packed_ff <= '0;
         nlen_ff   <= '0;
         skip_ff   <= MARKER_LEN;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         bib_ff    <= bib_in;
         type_ff   <= type_in;
         hsize_ff  <= hsize_in;
         packed_ff <= packed_in;
         nlen_ff   <= nlen_in;
         skip_ff   <= skip_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/rar_block_header_walker.sv
// Where an accepted byte yields a result word, it appears on rsp_ in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the single output register accepts a new
// byte whenever it is empty or being drained in the same cycle.
// Reset (synchronous, active high) returns to the marker skip with seven
// bytes to skip, clears the file count and empties the output register.
// ----------------------------------------------------------------------------
// rar_block_header_walker: RAR v4 block header walker
// Emits file name bytes of each file block and the total file count on end.
// ----------------------------------------------------------------------------
module rar_block_header_walker #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_value,
   output logic [15:0] rsp_file_number,
   output logic        rsp_last_of_name
);
   import rbhw_pkg::*;

   logic    req_fire;
   rsp_type result;
   rsp_type out_ff, out_in;

   assign req_ready = !out_ff.valid || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   rbhw_parser #(
      .COUNT_BITS(COUNT_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .data_byte (req_data_byte),
      .is_end    (req_is_end),
      .result    (result)
   );

   always_comb begin
      out_in = out_ff;
      if (req_fire)
         out_in = result;
      else if (rsp_ready)
         out_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.kind         <= out_in.kind;
      out_ff.value        <= out_in.value;
      out_ff.file_number  <= out_in.file_number;
      out_ff.last_of_name <= out_in.last_of_name;
   end

   assign rsp_valid        = out_ff.valid;
   assign rsp_kind         = out_ff.kind;
   assign rsp_value        = out_ff.value;
   assign rsp_file_number  = out_ff.file_number;
   assign rsp_last_of_name = out_ff.last_of_name;

endmodule

### hw/rtl/rbhw_checker.sv
// ----------------------------------------------------------------------------
// rbhw_checker: port-level checks for the RAR block header walker
// Watches the request and result channels and flags ordering slips.
// ----------------------------------------------------------------------------
module rbhw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_is_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_value,
   input logic [15:0] rsp_file_number,
   input logic        rsp_last_of_name
);
   import rbhw_pkg::*;

   // a stalled result word must hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_file_number) && $stable(rsp_last_of_name))
      else $error("result word changed while stalled");

   // an accepted end word yields a count word in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_end |=> rsp_valid && rsp_kind == KIND_COUNT)
      else $error("end word did not produce a count word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_COUNT |-> rsp_file_number == 16'd0 && !rsp_last_of_name)
      else $error("count word carries name fields");

   // a name byte belongs to a file already counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NAME |-> rsp_file_number != 16'd0 && rsp_value[15:8] == 8'd0)
      else $error("name byte with no owning file");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind rar_block_header_walker rbhw_checker u_rbhw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_data_byte    (req_data_byte),
   .req_is_end       (req_is_end),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_value        (rsp_value),
   .rsp_file_number  (rsp_file_number),
   .rsp_last_of_name (rsp_last_of_name)
);
